/* sv/d2s_pkg.sv */
// ----------------------------------------------------------------------------
// d2s_pkg
// Shared types and constants of the binary64 to binary32 converter.
// ----------------------------------------------------------------------------
package d2s_pkg;

  localparam int unsigned EXP64_W = 11;
  localparam int unsigned MANT64_W = 52;
  localparam int unsigned EXP32_W = 8;
  localparam int unsigned MANT32_W = 23;
  localparam int unsigned SIG_W = 54;

  localparam logic [EXP64_W-1:0] EXP64_ALL_ONES = 11'h7ff;
  localparam logic [EXP32_W-1:0] EXP32_MAX = 8'hff;
  // biased binary64 exponent of unbiased -126 and +127
  localparam logic [EXP64_W-1:0] EXP64_MIN_NORM = 11'd897;
  localparam logic [EXP64_W-1:0] EXP64_MAX_NORM = 11'd1150;
  // subnormal path: shift = 926 - exponent, zero when shift reaches 54
  localparam logic [EXP64_W-1:0] EXP64_SUB_BASE = 11'd926;
  localparam logic [EXP64_W-1:0] EXP64_SUB_FLOOR = 11'd872;
  // re-bias from binary64 to binary32: 1023 - 127
  localparam logic [EXP64_W-1:0] EXP_REBIAS = 11'd896;

  typedef enum logic {
    RND_RNE = 1'b0,
    RND_RTZ = 1'b1
  } rnd_mode_e;

  // stage 1 to stage 2 classification
  typedef struct packed {
    logic                sign;
    logic [EXP32_W-1:0]  exp;
    logic                fixed;     // result fully known, no rounding
    logic [MANT32_W-1:0] fixed_man;
    logic                rtz;
  } cls_t;

endpackage

/* sv/double_to_single_float_convert_unit.sv */
// ----------------------------------------------------------------------------
// double_to_single_float_convert_unit
// Converts binary64 bits to binary32 bits with nearest-even or toward-zero.
// ----------------------------------------------------------------------------
// One transaction in per cycle unless stalled, through a three-stage pipeline
// (align, round, pack), held as a whole while a result waits under out_stall_i.
// The input is stalled whenever a result waits at the output under out_stall_i.
module double_to_single_float_convert_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] double_bits_i,
  input  logic        opcode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] single_bits_o
);
  import d2s_pkg::*;

  logic en;

  // pipe advances unless the output holds a waiting transaction
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  d2s_round u_round (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_valid_i),
    .double_bits_i (double_bits_i),
    .rtz_i         (opcode_i == RND_RTZ),
    .valid_o       (out_valid_o),
    .single_bits_o (single_bits_o)
  );

`ifndef SYNTHESIS
  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(single_bits_o))
    else $error("stalled result changed");
  // input stall only under output stall
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i && out_valid_o)
    else $error("spurious input stall");
  // no stall while no result is pending
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("stall while empty");
`endif

endmodule

/* sv/d2s_round.sv */
// ----------------------------------------------------------------------------
// d2s_round
// Three-stage datapath: classify and align, round increment, pack result.
// ----------------------------------------------------------------------------
module d2s_round (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] double_bits_i,
  input  logic        rtz_i,
  output logic        valid_o,
  output logic [31:0] single_bits_o
);
  import d2s_pkg::*;

  logic [EXP64_W-1:0] ex;
  logic [MANT64_W-1:0] mant;
  logic [SIG_W-1:0] sig_ext;
  logic [EXP64_W-1:0] sh_full;
  logic [5:0] sh;
  logic [SIG_W+1:0] wide, shifted;
  cls_t cls_d, cls_q;
  logic [SIG_W-1:0] q_d, q_q;     // truncated quotient
  logic guard_d, guard_q, sticky_d, sticky_q;
  logic v1_q, v2_q, v3_q;
  logic [MANT32_W:0] m2_d, m2_q;
  cls_t cls2_q;
  logic [31:0] res_d, res_q;
  logic [EXP32_W-1:0] e3;

  // stage 1: classify and align into quotient, guard and sticky
  always_comb begin
    ex = double_bits_i[62:52];
    mant = double_bits_i[51:0];
    sig_ext = {1'b0, 1'b1, mant};
    cls_d = '0;
    cls_d.sign = double_bits_i[63];
    cls_d.rtz = rtz_i;
    sh_full = EXP64_SUB_BASE - ex;
    sh = sh_full[5:0];
    wide = '0;
    shifted = '0;
    q_d = '0;
    guard_d = 1'b0;
    sticky_d = 1'b0;
    if (ex == '0) begin
      cls_d.fixed = 1'b1;
    end else if (ex == EXP64_ALL_ONES) begin
      cls_d.fixed = 1'b1;
      cls_d.exp = EXP32_MAX;
      cls_d.fixed_man = (mant != '0) ? 23'd1 : '0;
    end else if (ex < EXP64_MIN_NORM) begin
      if (ex <= EXP64_SUB_FLOOR) begin
        cls_d.fixed = 1'b1;
      end else begin
        // two extra low bits give guard at bit sh+1; sticky from bits below it
        wide = {sig_ext, 2'b00};
        shifted = wide >> sh;
        q_d = shifted[SIG_W+1:2];
        guard_d = shifted[1];
        sticky_d = ((wide & ((({{(SIG_W+1){1'b0}}, 1'b1}) << (sh + 6'd1)) -
                    {{(SIG_W+1){1'b0}}, 1'b1})) != '0);
      end
    end else if (ex > EXP64_MAX_NORM) begin
      cls_d.fixed = 1'b1;
      cls_d.exp = EXP32_MAX;
    end else begin
      cls_d.exp = EXP32_W'(ex - EXP_REBIAS);
      q_d = {31'd0, mant[51:29]};
      guard_d = mant[28];
      sticky_d = (mant[27:0] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cls_q <= cls_d;
      q_q <= q_d;
      guard_q <= guard_d;
      sticky_q <= sticky_d;
    end
  end

  // stage 2: round increment
  always_comb begin
    m2_d = q_q[MANT32_W:0];
    if (cls_q.rtz == 1'b0 && guard_q && (sticky_q || q_q[0])) begin
      m2_d = q_q[MANT32_W:0] + 24'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m2_q <= m2_d;
      cls2_q <= cls_q;
    end
  end

  // stage 3: mantissa carry and pack
  always_comb begin
    e3 = cls2_q.exp + EXP32_W'(m2_q[MANT32_W]);
    if (cls2_q.fixed) begin
      res_d = {cls2_q.sign, cls2_q.exp, cls2_q.fixed_man};
    end else begin
      res_d = {cls2_q.sign, e3, m2_q[MANT32_W-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = v3_q;
  assign single_bits_o = res_q;

`ifndef SYNTHESIS
  // a frozen pipe holds its valid bits
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(v3_q) && $stable(v2_q))
    else $error("pipe moved while frozen");
  // valid advances one stage per enabled cycle
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> v2_q == $past(v1_q))
    else $error("valid lost between stages");
  // rounded mantissa never overflows past one carry
  a_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && m2_q[MANT32_W] && !cls2_q.fixed |-> m2_q[MANT32_W-1:0] == '0)
    else $error("mantissa carry with nonzero fraction");
`endif

endmodule

/* verif/double_to_single_float_convert_unit_tb.sv */
// ----------------------------------------------------------------------------
// double_to_single_float_convert_unit_tb
// Self-checking bench: drives binary64 operands with both rounding modes,
// predicts each binary32 result and compares it in order at the output.
// ----------------------------------------------------------------------------
module double_to_single_float_convert_unit_tb;
  import d2s_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] double_bits_i;
  logic        opcode_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] single_bits_o;

  logic [31:0] single_queue[$];
  int unsigned mismatch_count;
  int unsigned sent_count;
  int unsigned recv_count;
  int unsigned idle_cycles;
  int unsigned idle_pct;

  double_to_single_float_convert_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .double_bits_i(double_bits_i),
    .opcode_i(opcode_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .single_bits_o(single_bits_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // shift right and round, rtz truncates
  function automatic logic [63:0] shift_round(logic [63:0] v, int unsigned sh, logic rtz);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    q = v >> sh;
    rem = v & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (!rtz && (rem > half || (rem == half && q[0]))) q = q + 64'd1;
    return q;
  endfunction

  // predicted binary32 bits of one operand
  function automatic logic [31:0] narrow_double(logic [63:0] bits, rnd_mode_e mode);
    logic        rtz;
    int          ex;
    logic [63:0] e;
    logic [63:0] m;
    rtz = (mode == RND_RTZ);
    ex = int'(bits[62:52]);
    e = 64'd0;
    m = 64'd0;
    if (ex == 0) begin
      e = 64'd0;
    end else if (ex == 2047) begin
      e = 64'd255;
      m = (bits[51:0] != 0) ? 64'd1 : 64'd0;
    end else if (ex - 1023 < -126) begin
      if (926 - ex < 55) m = shift_round({11'd0, 1'b1, bits[51:0]}, 926 - ex, rtz);
    end else if (ex - 1023 > 127) begin
      e = 64'd255;
    end else begin
      e = 64'(ex - 896);
      m = shift_round({12'd0, bits[51:0]}, 29, rtz);
    end
    if (m == (64'd1 << 23)) begin
      e = e + 64'd1;
      m = 64'd0;
    end
    return {bits[63], e[7:0], m[22:0]};
  endfunction

  // mismatch report
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("mismatch %0d: %s got %08h want %08h", mismatch_count, what, got, want);
  endtask

  function automatic logic roll_idle();
    return ($urandom_range(99) < idle_pct);
  endfunction

  // send one transaction and record its expectation
  task automatic send_double(logic [63:0] bits, logic op);
    while (roll_idle()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    double_bits_i <= bits;
    opcode_i <= op;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    single_queue.push_back(narrow_double(bits, rnd_mode_e'(op)));
    sent_count++;
  endtask

  // build an operand from fields
  function automatic logic [63:0] mk(logic s, int unsigned ex, logic [51:0] man);
    return {s, ex[10:0], man};
  endfunction

  // extremes and special cases
  task automatic test_directed();
    logic [51:0] all_ones;
    all_ones = '1;
    for (int op = 0; op < 2; op++) begin
      send_double(64'h0, 1'(op));
      send_double(mk(1'b1, 0, all_ones), 1'(op));
      send_double(mk(1'b0, 2047, 52'd0), 1'(op));
      send_double(mk(1'b1, 2047, 52'h8_0000_0000_0001), 1'(op));
      send_double(mk(1'b0, 1150, all_ones), 1'(op));
      send_double(mk(1'b1, 1151, 52'd0), 1'(op));
      send_double(mk(1'b0, 897, 52'h0_0000_1000_0000), 1'(op));
      send_double(mk(1'b0, 896, all_ones), 1'(op));
      send_double(mk(1'b1, 872, all_ones), 1'(op));
      send_double(mk(1'b0, 871, all_ones), 1'(op));
      send_double(mk(1'b0, 1023, 52'h0_0000_3000_0000), 1'(op));
    end
    send_double(64'hffff_ffff_ffff_ffff, 1'b1);
  endtask

  // random operands, biased toward the interesting exponents
  task automatic test_random(int unsigned n);
    logic [63:0] bits;
    for (int unsigned i = 0; i < n; i++) begin
      bits = {$urandom, $urandom};
      case ($urandom_range(4))
        0: bits[62:52] = 11'($urandom_range(1150, 897));
        1: bits[62:52] = 11'($urandom_range(900, 868));
        2: bits[62:52] = 11'($urandom_range(1) ? 2047 : 0);
        3: begin
          bits[62:52] = 11'($urandom_range(1155, 1145));
          bits[28:0] = $urandom_range(1) ? 29'h1000_0000 : 29'h1fff_ffff;
        end
        default: ;
      endcase
      send_double(bits, 1'($urandom_range(1)));
    end
  endtask

  // output stall and result check
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        recv_count++;
        if (single_queue.size() == 0) begin
          report_mismatch("unexpected result", single_bits_o, 32'h0);
        end else begin
          logic [31:0] want;
          want = single_queue.pop_front();
          if (single_bits_o !== want) report_mismatch("single_bits", single_bits_o, want);
        end
      end
      out_stall_i <= roll_idle();
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("[double_to_single_float_convert_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    double_bits_i = '0;
    opcode_i = 1'b0;
    out_stall_i = 1'b0;
    mismatch_count = 0;
    sent_count = 0;
    recv_count = 0;
    idle_cycles = 0;
    idle_pct = 32;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(600);
    idle_pct = 0;
    test_random(250);
    idle_pct = 32;
    test_random(400);
    in_valid_i <= 1'b0;
    while (single_queue.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("sent %0d operands, checked %0d results, both rounding modes", sent_count,
             recv_count);
    if (mismatch_count == 0 && single_queue.size() == 0) begin
      $display("[double_to_single_float_convert_unit] OK");
    end else begin
      $display("[double_to_single_float_convert_unit] ERROR");
    end
    $finish;
  end

endmodule
